// ===== design/rggi_pkg.sv =====
// ---------------------------------------------------------------------------
// rggi_pkg: shared types and constants for the RGB gain and gamma block
// Widths of the pixel and table fields, the request codes and the
// per-stage load controls that the top level hands to each channel.
// ---------------------------------------------------------------------------
package rggi_pkg;

   localparam int CHAN_W      = 16;
   localparam int GAIN_W      = 8;
   localparam int GAIN_SHIFT  = 7;
   localparam int PROD_W      = CHAN_W + GAIN_W;
   localparam int FRAC_BITS   = 8;
   localparam int TBL_ENTRIES = 257;
   localparam int TBL_ADDR_W  = $clog2(TBL_ENTRIES);
   localparam int TBL_DATA_W  = 8;
   localparam int IDX_W       = CHAN_W - FRAC_BITS;
   localparam int DIFF_W      = TBL_DATA_W + 1;
   localparam int INTERP_W    = DIFF_W + FRAC_BITS;

   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(128);

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 24;

   typedef enum logic {
      OP_PIXEL       = 1'b0,
      OP_TABLE_WRITE = 1'b1
   } op_type;

   // Load enables of the four pipeline stages, one set for all channels.
   typedef struct packed {
      logic s1_en;
      logic s2_en;
      logic s3_en;
      logic s4_en;
   } pipe_ctl_type;

endpackage

// ===== design/rggi_gamma_ram.sv =====
// ---------------------------------------------------------------------------
// rggi_gamma_ram: gamma table storage
// One write port and two registered read ports, so that an entry and its
// upper neighbor are fetched together for interpolation.
// ---------------------------------------------------------------------------
module rggi_gamma_ram
   import rggi_pkg::*;
(
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [TBL_ADDR_W-1:0] wr_addr,
   input  logic [TBL_DATA_W-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [TBL_ADDR_W-1:0] rd_addr_a,
   input  logic [TBL_ADDR_W-1:0] rd_addr_b,
   output logic [TBL_DATA_W-1:0] rd_data_a,
   output logic [TBL_DATA_W-1:0] rd_data_b
);

   logic [TBL_DATA_W-1:0] gamma_mem_ff [TBL_ENTRIES];
   logic [TBL_DATA_W-1:0] rd_data_a_ff;
   logic [TBL_DATA_W-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         gamma_mem_ff[wr_addr] <= wr_data;
      end
   end

   // The read registers hold while the stage they feed is stalled.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= gamma_mem_ff[rd_addr_a];
         rd_data_b_ff <= gamma_mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== design/rggi_channel.sv =====
// ---------------------------------------------------------------------------
// rggi_channel: datapath of one color channel
// Gain multiply, saturation and table fetch, difference times fraction,
// and the final floor shift and add, each ending in a stage register.
// ---------------------------------------------------------------------------
module rggi_channel
   import rggi_pkg::*;
(
   input  logic                  clock,
   input  pipe_ctl_type          ctl,
   input  logic [CHAN_W-1:0]     chan_in,
   input  logic [GAIN_W-1:0]     gain,
   input  logic                  tbl_we,
   input  logic [TBL_ADDR_W-1:0] tbl_addr,
   input  logic [TBL_DATA_W-1:0] tbl_data,
   output logic [TBL_DATA_W-1:0] chan_out
);

   localparam int SCALED_W = PROD_W - GAIN_SHIFT;

   logic [PROD_W-1:0]          prod_ff;
   logic [PROD_W-1:0]          prod_in;
   logic [SCALED_W-1:0]        scaled;
   logic [CHAN_W-1:0]          sat_value;
   logic [TBL_ADDR_W-1:0]      addr_lo;
   logic [TBL_ADDR_W-1:0]      addr_hi;
   logic [FRAC_BITS-1:0]       frac2_ff;
   logic [TBL_DATA_W-1:0]      lo2;
   logic [TBL_DATA_W-1:0]      hi2;
   logic signed [DIFF_W-1:0]   diff;
   logic signed [INTERP_W-1:0] interp_in;
   logic signed [INTERP_W-1:0] interp3_ff;
   logic [TBL_DATA_W-1:0]      lo3_ff;
   logic signed [INTERP_W-FRAC_BITS-1:0] step;
   logic [TBL_DATA_W-1:0]      out_in;
   logic [TBL_DATA_W-1:0]      out4_ff;

   // Stage 1: 16 x 8 gain product.
   assign prod_in = PROD_W'(chan_in) * PROD_W'(gain);

   always_ff @(posedge clock) begin
      if (ctl.s1_en) begin
         prod_ff <= prod_in;
      end
   end

   // Stage 2: Q1.7 shift, clamp to the channel range, fetch both neighbors.
   assign scaled    = prod_ff[PROD_W-1:GAIN_SHIFT];
   assign sat_value = scaled[SCALED_W-1] ? {CHAN_W{1'b1}} : scaled[CHAN_W-1:0];
   assign addr_lo   = TBL_ADDR_W'(sat_value[CHAN_W-1:FRAC_BITS]);
   assign addr_hi   = addr_lo + TBL_ADDR_W'(1);

   always_ff @(posedge clock) begin
      if (ctl.s2_en) begin
         frac2_ff <= sat_value[FRAC_BITS-1:0];
      end
   end

   rggi_gamma_ram u_ram (
      .clock     (clock),
      .wr_en     (tbl_we),
      .wr_addr   (tbl_addr),
      .wr_data   (tbl_data),
      .rd_en     (ctl.s2_en),
      .rd_addr_a (addr_lo),
      .rd_addr_b (addr_hi),
      .rd_data_a (lo2),
      .rd_data_b (hi2)
   );

   // Stage 3: signed difference times fraction.
   assign diff      = $signed({1'b0, hi2}) - $signed({1'b0, lo2});
   assign interp_in = INTERP_W'(diff) * $signed({{(INTERP_W-FRAC_BITS){1'b0}}, frac2_ff});

   always_ff @(posedge clock) begin
      if (ctl.s3_en) begin
         interp3_ff <= interp_in;
         lo3_ff     <= lo2;
      end
   end

   // Stage 4: the arithmetic shift rounds toward minus infinity, then the
   // sum wraps to eight bits.
   assign step   = interp3_ff[INTERP_W-1:FRAC_BITS];
   assign out_in = lo3_ff + step[TBL_DATA_W-1:0];

   always_ff @(posedge clock) begin
      if (ctl.s4_en) begin
         out4_ff <= out_in;
      end
   end

   assign chan_out = out4_ff;

endmodule

// ===== design/rgb_gain_gamma_interpolate.sv =====
// ---------------------------------------------------------------------------
// rgb_gain_gamma_interpolate: brightness gain and interpolated gamma lookup
//
// Requests arrive on the req_ channel. A pixel request (req_tuser low)
// carries three 16-bit channels; each is scaled by the Q1.7 gain, clamped
// at 65535 and mapped through a 257-entry gamma table with linear
// interpolation between neighboring entries. A table request (req_tuser
// high) writes one table entry and produces no response; indexes above
// 256 are dropped. Load the table before sending pixels that use it.
// The user must write the gain through csr_we/csr_wdata only while the
// block is idle; the block does not enforce this. Reset sets the gain to
// 128 (unity). Reset empties the pipeline but does not touch the table.
// Four register stages: a pixel response leaves from the last stage
// register, and one request is taken every cycle unless rsp_tready stalls
// a full pipeline. The gain multiplier, the dual-read table copy per
// channel and the difference multiplier set the stage boundaries. Each
// stage has its own valid bit, so bubbles close up while rsp_tready is
// low and req_tready only drops once all four stages hold work.
// ---------------------------------------------------------------------------
module rgb_gain_gamma_interpolate
   import rggi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [15:0] red_in, [31:16] green_in, [47:32] blue_in,
   // [56:48] entry_index, [64:57] entry_value, [71:65] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] operation
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] red_out, [15:8] green_out, [23:16] blue_out
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [GAIN_W-1:0]     csr_wdata
);

   logic [GAIN_W-1:0]     gain_ff;
   logic [GAIN_W-1:0]     gain_in;

   logic                  v1_ff, v2_ff, v3_ff, v4_ff;
   logic                  v1_in, v2_in, v3_in, v4_in;
   logic                  rdy1, rdy2, rdy3, rdy4;
   op_type                op1_ff;
   logic [TBL_ADDR_W-1:0] idx1_ff;
   logic [TBL_DATA_W-1:0] val1_ff;
   logic                  s1_pixel;
   logic                  tbl_we;
   pipe_ctl_type          ctl;

   logic [CHAN_W-1:0]     red_in, green_in, blue_in;
   logic [TBL_DATA_W-1:0] red_out, green_out, blue_out;

   assign red_in   = req_tdata[15:0];
   assign green_in = req_tdata[31:16];
   assign blue_in  = req_tdata[47:32];

   // Gain register.
   assign gain_in = csr_we ? csr_wdata : gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else begin
         gain_ff <= gain_in;
      end
   end

   // Per-stage handshake: a stage takes new work when it is empty or when
   // its content moves on in the same cycle.
   assign rdy4 = !v4_ff || rsp_tready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign s1_pixel = (op1_ff == OP_PIXEL);

   assign ctl.s1_en = req_tvalid && rdy1;
   assign ctl.s2_en = v1_ff && s1_pixel && rdy2;
   assign ctl.s3_en = v2_ff && rdy3;
   assign ctl.s4_en = v3_ff && rdy4;

   // A table request writes as it leaves stage 1, the same point where
   // pixels read, so a later pixel always sees the new entry.
   assign tbl_we = v1_ff && !s1_pixel && rdy2 && (idx1_ff < TBL_ADDR_W'(TBL_ENTRIES));

   always_comb begin
      v1_in = rdy1 ? req_tvalid : v1_ff;
      v2_in = rdy2 ? (v1_ff && s1_pixel) : v2_ff;
      v3_in = rdy3 ? v2_ff : v3_ff;
      v4_in = rdy4 ? v3_ff : v4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.s1_en) begin
         op1_ff  <= op_type'(req_tuser);
         idx1_ff <= req_tdata[56:48];
         val1_ff <= req_tdata[64:57];
      end
   end

   rggi_channel u_red (
      .clock    (clock),
      .ctl      (ctl),
      .chan_in  (red_in),
      .gain     (gain_ff),
      .tbl_we   (tbl_we),
      .tbl_addr (idx1_ff),
      .tbl_data (val1_ff),
      .chan_out (red_out)
   );

   rggi_channel u_green (
      .clock    (clock),
      .ctl      (ctl),
      .chan_in  (green_in),
      .gain     (gain_ff),
      .tbl_we   (tbl_we),
      .tbl_addr (idx1_ff),
      .tbl_data (val1_ff),
      .chan_out (green_out)
   );

   rggi_channel u_blue (
      .clock    (clock),
      .ctl      (ctl),
      .chan_in  (blue_in),
      .gain     (gain_ff),
      .tbl_we   (tbl_we),
      .tbl_addr (idx1_ff),
      .tbl_data (val1_ff),
      .chan_out (blue_out)
   );

   assign req_tready = rdy1;
   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {blue_out, green_out, red_out};

`ifndef SYNTH
   // Back-pressure reaches the input only when every stage is occupied.
   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (v1_ff && v2_ff && v3_ff && v4_ff))
      else $error("input blocked while a stage is empty");

   // A table write never shares its slot with a pixel entering stage 2.
   a_write_no_read: assert property (@(posedge clock) disable iff (reset)
      tbl_we |-> !ctl.s2_en)
      else $error("table write and pixel fetch in the same cycle");

   // Stage 2 only fills from a pixel request held in stage 1.
   a_s2_from_pixel: assert property (@(posedge clock) disable iff (reset)
      $rose(v2_ff) |-> $past(v1_ff && (op1_ff == OP_PIXEL)))
      else $error("stage 2 filled without a pixel in stage 1");
`endif

endmodule
